/* rtl/core/dd_odo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dd_odo_pkg
// shared types, constants and the arctangent table of the odometry core
// ----------------------------------------------------------------------------
package dd_odo_pkg;

    localparam int ROTATION_STEPS = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int CORDIC_STEPS   = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                                    (ROTATION_STEPS < 1) ? 1 : ROTATION_STEPS;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [51:0] PI_Q16      = 52'sd205887;
    localparam logic [31:0]        TURN_Q16    = 32'd411775;
    // floor(2^51 / one turn), for the heading reduction
    localparam logic [33:0]        TURN_RECIP  = 34'((64'd1 << 51) / 64'd411775);
    localparam logic [33:0]        MICRO       = 34'd1000000;

    localparam logic CFG_RADIUS     = 1'b0;
    localparam logic CFG_SEPARATION = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_DIST,
        ST_MUL_TURN,
        ST_DIV_TURN,
        ST_WAIT_TURN,
        ST_HEAD_EST,
        ST_HEAD_BACK,
        ST_HEAD_FIX,
        ST_CORDIC_POSE,
        ST_WAIT_POSE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_WAIT_QUAT,
        ST_VEL_LO,
        ST_VEL_HI,
        ST_VEL_DIV,
        ST_VEL_WAIT,
        ST_DONE
    } state_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        begin
            unique case (idx)
                5'd0:  v = 34'sd843314857;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd10: v = 34'sd1048576;
                5'd11: v = 34'sd524288;
                5'd12: v = 34'sd262144;
                5'd13: v = 34'sd131072;
                5'd14: v = 34'sd65536;
                5'd15: v = 34'sd32768;
                5'd16: v = 34'sd16384;
                5'd17: v = 34'sd8192;
                5'd18: v = 34'sd4096;
                5'd19: v = 34'sd2048;
                5'd20: v = 34'sd1024;
                5'd21: v = 34'sd512;
                5'd22: v = 34'sd256;
                5'd23: v = 34'sd128;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/dd_odo_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dd_odo_mul
// shared signed multiplier, product registered
// ----------------------------------------------------------------------------
module dd_odo_mul (
    input  wire logic               clk,
    input  wire logic signed [33:0] a,
    input  wire logic signed [33:0] b,
    output logic signed [67:0]      prod
);

    logic signed [67:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(a) * 68'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* rtl/core/dd_odo_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dd_odo_div
// restoring divider, 64 by 32 bits unsigned, one quotient bit a cycle
// ----------------------------------------------------------------------------
module dd_odo_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [63:0]      quot
);

    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

/* rtl/core/dd_odo_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dd_odo_cordic
// iterative rotation cordic, q4.30, one micro-rotation a cycle
// ----------------------------------------------------------------------------
module dd_odo_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [33:0] angle,
    output logic                    done,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic [4:0]         idx_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [33:0] dx, dy, at;

    assign dx = y_reg >>> idx_reg;
    assign dy = x_reg >>> idx_reg;
    assign at = dd_odo_pkg::atan_q30(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 5'd1;
                if (idx_reg == 5'(dd_odo_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= dd_odo_pkg::GAIN_Q30;
            y_reg <= '0;
            // fold angles beyond a quarter turn back by pi
            if (angle > dd_odo_pkg::HALF_PI_Q30)
            begin
                z_reg    <= angle - dd_odo_pkg::PI_Q30;
                flip_reg <= 1'b1;
            end
            else if (angle < -dd_odo_pkg::HALF_PI_Q30)
            begin
                z_reg    <= angle + dd_odo_pkg::PI_Q30;
                flip_reg <= 1'b1;
            end
            else
            begin
                z_reg    <= angle;
                flip_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

/* rtl/core/diff_drive_wheel_odometry.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_wheel_odometry
// differential-drive wheel odometry over a shared multiplier, divider and cordic
// ----------------------------------------------------------------------------
// a new sample is taken only in idle, once the result of the last one has moved into
// the output register; most of the work per sample lies in the divider, run up to three
// times (once with a zero time step), and in two cordic passes; a held result adds its stall
// the result waits in an output register, so the next sample can be taken while it waits
// reset: pose, heading and previous sample cleared, radius 2163, separation 11141
// ----------------------------------------------------------------------------
module diff_drive_wheel_odometry (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // sample channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] right_angle,
    input  wire logic signed [31:0] left_angle,
    input  wire logic [31:0]        stamp_us,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [18:0]      heading,
    output logic signed [17:0]      quat_z,
    output logic signed [17:0]      quat_w,
    output logic signed [31:0]      linear_velocity,
    output logic signed [31:0]      angular_velocity,
    output logic                    zero_interval,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [19:0]        cfg_data
);

    dd_odo_pkg::state_t state_reg, state_next;

    // configuration
    logic [15:0] radius_reg;
    logic [19:0] sep_reg;
    logic [19:0] sep_eff;

    // persistent state
    logic [31:0]        last_r_reg, last_l_reg, last_t_reg;
    logic [31:0]        acc_x_reg, acc_y_reg;
    logic signed [19:0] acc_head_reg;

    // per-sample working registers
    logic signed [31:0] dr_reg, dl_reg;
    logic [31:0]        dt_reg;
    logic signed [32:0] dist_reg;
    logic signed [50:0] turn_reg;
    logic               neg_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic signed [17:0] qz_reg, qw_reg;
    logic               sel_reg;
    logic [11:0]        vmag_reg;
    logic               big_reg;
    logic [63:0]        plo_reg;
    logic signed [31:0] lin_reg, ang_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] o_x_reg, o_y_reg, o_lin_reg, o_ang_reg;
    logic signed [18:0] o_head_reg;
    logic signed [17:0] o_qz_reg, o_qw_reg;
    logic               o_zero_reg;

    // shared units
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic               div_start, div_done;
    logic [63:0]        div_num, div_quot;
    logic [31:0]        div_den;
    logic               cor_start, cor_done;
    logic signed [33:0] cor_angle, cor_c, cor_s;

    // helpers
    logic               in_xfer, out_free;
    logic signed [49:0] tprod;
    logic [49:0]        tmag;
    logic signed [51:0] head_sum;
    logic [49:0]        head_mag;
    logic [49:0]        head_r0;
    logic [31:0]        head_rem;
    logic [31:0]        head_mod;
    logic signed [50:0] vval;
    logic [50:0]        vabs;
    logic [63:0]        vq;
    logic signed [31:0] vsat;
    logic signed [67:0] x_round, y_round;
    logic signed [19:0] qz_wide, qw_wide;

    dd_odo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    dd_odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    dd_odo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_c),
        .sin_out (cor_s)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != dd_odo_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    // a separation of zero acts as one
    assign sep_eff   = (sep_reg == 20'd0) ? 20'd1 : sep_reg;

    // turn numerator magnitude
    assign tprod = prod[49:0];
    assign tmag  = tprod[49] ? 50'(-tprod) : 50'(tprod);

    // heading wrap: t = heading + turn + pi, reduced modulo one turn
    assign head_sum = 52'(acc_head_reg) + 52'(turn_reg) + dd_odo_pkg::PI_Q16;
    assign head_mag = head_sum[51] ? 50'(-head_sum) : 50'(head_sum);

    // the reciprocal estimate of the quotient is at most two low, so the
    // remainder left after taking it off is below three turns
    assign head_r0 = head_mag - prod[49:0];
    always_comb
    begin
        if (head_r0 >= 50'(dd_odo_pkg::TURN_Q16) * 50'd3)
            head_rem = 32'(head_r0 - 50'(dd_odo_pkg::TURN_Q16) * 50'd3);
        else if (head_r0 >= 50'(dd_odo_pkg::TURN_Q16) * 50'd2)
            head_rem = 32'(head_r0 - 50'(dd_odo_pkg::TURN_Q16) * 50'd2);
        else if (head_r0 >= 50'(dd_odo_pkg::TURN_Q16))
            head_rem = 32'(head_r0 - 50'(dd_odo_pkg::TURN_Q16));
        else
            head_rem = 32'(head_r0);
    end

    assign head_mod = !neg_reg ? head_rem :
                      (head_rem == 32'd0) ? 32'd0 : dd_odo_pkg::TURN_Q16 - head_rem;

    // velocity operand: distance first, then turn
    assign vval = sel_reg ? turn_reg : 51'(dist_reg);
    assign vabs = vval[50] ? 51'(-vval) : 51'(vval);

    // rounding of the pose steps
    assign x_round = (prod + 68'sd536870912) >>> 30;
    assign y_round = x_round;

    // q30 to q16 with rounding, clamped to one
    assign qz_wide = 20'((cor_s + 34'sd8192) >>> 14);
    assign qw_wide = 20'((cor_c + 34'sd8192) >>> 14);

    // velocity quotient and saturation
    assign vq = big_reg ? 64'h1_0000_0000 : div_quot;
    always_comb
    begin
        if (!neg_reg)
            vsat = (vq > 64'd2147483647) ? 32'sh7FFF_FFFF : $signed(vq[31:0]);
        else
            vsat = (vq > 64'd2147483648) ? 32'sh8000_0000 : $signed(32'(-vq[31:0]));
    end

    // shared unit operand selection and sequencing
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        cor_start  = 1'b0;
        cor_angle  = '0;
        unique case (state_reg)
            dd_odo_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = dd_odo_pkg::ST_MUL_DIST;
            end
            dd_odo_pkg::ST_MUL_DIST:
            begin
                mul_a      = 34'(dr_reg) + 34'(dl_reg);
                mul_b      = $signed({18'd0, radius_reg});
                state_next = dd_odo_pkg::ST_MUL_TURN;
            end
            dd_odo_pkg::ST_MUL_TURN:
            begin
                mul_a      = 34'(dr_reg) - 34'(dl_reg);
                mul_b      = $signed({18'd0, radius_reg});
                state_next = dd_odo_pkg::ST_DIV_TURN;
            end
            dd_odo_pkg::ST_DIV_TURN:
            begin
                div_start  = 1'b1;
                div_num    = 64'(tmag) + 64'(sep_eff[19:1]);
                div_den    = 32'(sep_eff);
                state_next = dd_odo_pkg::ST_WAIT_TURN;
            end
            dd_odo_pkg::ST_WAIT_TURN:
            begin
                if (div_done)
                    state_next = dd_odo_pkg::ST_HEAD_EST;
            end
            dd_odo_pkg::ST_HEAD_EST:
            begin
                // quotient estimate from the top 32 bits and the reciprocal
                mul_a      = $signed({2'b00, head_mag[49:18]});
                mul_b      = $signed(dd_odo_pkg::TURN_RECIP);
                state_next = dd_odo_pkg::ST_HEAD_BACK;
            end
            dd_odo_pkg::ST_HEAD_BACK:
            begin
                // estimate times one turn
                mul_a      = $signed({2'b00, prod[64:33]});
                mul_b      = $signed({2'b00, dd_odo_pkg::TURN_Q16});
                state_next = dd_odo_pkg::ST_HEAD_FIX;
            end
            dd_odo_pkg::ST_HEAD_FIX:
            begin
                state_next = dd_odo_pkg::ST_CORDIC_POSE;
            end
            dd_odo_pkg::ST_CORDIC_POSE:
            begin
                cor_start  = 1'b1;
                cor_angle  = 34'(acc_head_reg) <<< 14;
                state_next = dd_odo_pkg::ST_WAIT_POSE;
            end
            dd_odo_pkg::ST_WAIT_POSE:
            begin
                if (cor_done)
                    state_next = dd_odo_pkg::ST_MUL_X;
            end
            dd_odo_pkg::ST_MUL_X:
            begin
                mul_a      = 34'(dist_reg);
                mul_b      = cos_reg;
                state_next = dd_odo_pkg::ST_MUL_Y;
            end
            dd_odo_pkg::ST_MUL_Y:
            begin
                mul_a      = 34'(dist_reg);
                mul_b      = sin_reg;
                state_next = dd_odo_pkg::ST_ADD_Y;
            end
            dd_odo_pkg::ST_ADD_Y:
            begin
                // half-angle pass for the quaternion
                cor_start  = 1'b1;
                cor_angle  = 34'(acc_head_reg) <<< 13;
                state_next = dd_odo_pkg::ST_WAIT_QUAT;
            end
            dd_odo_pkg::ST_WAIT_QUAT:
            begin
                if (cor_done)
                    state_next = (dt_reg == 32'd0) ? dd_odo_pkg::ST_DONE :
                                                     dd_odo_pkg::ST_VEL_LO;
            end
            dd_odo_pkg::ST_VEL_LO:
            begin
                mul_a      = $signed({2'b00, vabs[31:0]});
                mul_b      = $signed(dd_odo_pkg::MICRO);
                state_next = dd_odo_pkg::ST_VEL_HI;
            end
            dd_odo_pkg::ST_VEL_HI:
            begin
                mul_a      = $signed({22'd0, vmag_reg});
                mul_b      = $signed(dd_odo_pkg::MICRO);
                state_next = dd_odo_pkg::ST_VEL_DIV;
            end
            dd_odo_pkg::ST_VEL_DIV:
            begin
                div_start  = 1'b1;
                div_num    = {prod[31:0], 32'd0} + plo_reg + 64'(dt_reg[31:1]);
                div_den    = dt_reg;
                state_next = dd_odo_pkg::ST_VEL_WAIT;
            end
            dd_odo_pkg::ST_VEL_WAIT:
            begin
                if (div_done)
                    state_next = sel_reg ? dd_odo_pkg::ST_DONE : dd_odo_pkg::ST_VEL_LO;
            end
            dd_odo_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = dd_odo_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dd_odo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dd_odo_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd2163;
            sep_reg    <= 20'd11141;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dd_odo_pkg::CFG_RADIUS:     radius_reg <= cfg_data[15:0];
                dd_odo_pkg::CFG_SEPARATION: sep_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // persistent odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_r_reg   <= '0;
            last_l_reg   <= '0;
            last_t_reg   <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            acc_head_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                last_r_reg <= right_angle;
                last_l_reg <= left_angle;
                last_t_reg <= stamp_us;
            end
            if (state_reg == dd_odo_pkg::ST_HEAD_FIX)
                acc_head_reg <= 20'($signed({1'b0, head_mod}) - 33'sd205887);
            if (state_reg == dd_odo_pkg::ST_MUL_Y)
                acc_x_reg <= acc_x_reg + x_round[31:0];
            if (state_reg == dd_odo_pkg::ST_ADD_Y)
                acc_y_reg <= acc_y_reg + y_round[31:0];
        end
    end

    // per-sample datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            // wheel and time deltas, modulo 2^32
            dr_reg  <= right_angle - $signed(last_r_reg);
            dl_reg  <= left_angle - $signed(last_l_reg);
            dt_reg  <= stamp_us - last_t_reg;
            sel_reg <= 1'b0;
            lin_reg <= '0;
            ang_reg <= '0;
        end
        unique case (state_reg)
            dd_odo_pkg::ST_MUL_TURN:
            begin
                dist_reg <= 33'((prod + 68'sd65536) >>> 17);
            end
            dd_odo_pkg::ST_DIV_TURN:
            begin
                neg_reg <= tprod[49];
            end
            dd_odo_pkg::ST_WAIT_TURN:
            begin
                if (div_done)
                    turn_reg <= neg_reg ? -$signed({1'b0, div_quot[49:0]})
                                        : $signed({1'b0, div_quot[49:0]});
            end
            dd_odo_pkg::ST_HEAD_EST:
            begin
                neg_reg <= head_sum[51];
            end
            dd_odo_pkg::ST_WAIT_POSE:
            begin
                if (cor_done)
                begin
                    cos_reg <= cor_c;
                    sin_reg <= cor_s;
                end
            end
            dd_odo_pkg::ST_WAIT_QUAT:
            begin
                if (cor_done)
                begin
                    qz_reg <= (qz_wide > 20'sd65536) ? 18'sd65536 :
                              (qz_wide < -20'sd65536) ? -18'sd65536 : 18'(qz_wide);
                    qw_reg <= (qw_wide > 20'sd65536) ? 18'sd65536 :
                              (qw_wide < -20'sd65536) ? -18'sd65536 : 18'(qw_wide);
                end
            end
            dd_odo_pkg::ST_VEL_LO:
            begin
                vmag_reg <= vabs[43:32];
                big_reg  <= (vabs[50:44] != 7'd0);
                neg_reg  <= vval[50];
            end
            dd_odo_pkg::ST_VEL_HI:
            begin
                plo_reg <= prod[63:0];
            end
            dd_odo_pkg::ST_VEL_WAIT:
            begin
                if (div_done)
                begin
                    if (sel_reg)
                        ang_reg <= vsat;
                    else
                        lin_reg <= vsat;
                    sel_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register, refilled once the previous transfer has gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == dd_odo_pkg::ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dd_odo_pkg::ST_DONE && out_free)
        begin
            o_x_reg    <= $signed(acc_x_reg);
            o_y_reg    <= $signed(acc_y_reg);
            o_head_reg <= acc_head_reg[18:0];
            o_qz_reg   <= qz_reg;
            o_qw_reg   <= qw_reg;
            o_lin_reg  <= lin_reg;
            o_ang_reg  <= ang_reg;
            o_zero_reg <= (dt_reg == 32'd0);
        end
    end

    assign out_valid        = out_valid_reg;
    assign pos_x            = o_x_reg;
    assign pos_y            = o_y_reg;
    assign heading          = o_head_reg;
    assign quat_z           = o_qz_reg;
    assign quat_w           = o_qw_reg;
    assign linear_velocity  = o_lin_reg;
    assign angular_velocity = o_ang_reg;
    assign zero_interval    = o_zero_reg;

endmodule
`default_nettype wire

/* bench/tb_diff_drive_wheel_odometry.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_wheel_odometry
// self-checking bench for the wheel odometry core: a queue-fed driver offers
// wheel samples, an in-bench pose predictor forms the expected pose, quaternion
// and velocities, and a monitor compares every result transfer field by field
// ----------------------------------------------------------------------------
module tb_diff_drive_wheel_odometry;

    localparam int     PERIOD_NS   = 8;
    localparam int     RESET_CYC   = 6;
    localparam int     SETTLE_CYC  = 400;     // above the worst sample latency
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint PI_FX       = 205887;
    localparam longint TURN_FX     = 411775;
    localparam longint PI_30       = 64'sd3373259426;
    localparam longint HALF_PI_30  = 64'sd1686629713;
    localparam longint GAIN_30     = 64'sd652032874;
    localparam longint ROUND_30    = 64'sd536870912;
    localparam longint ATAN_TAB [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef struct {
        logic [31:0] ra;
        logic [31:0] la;
        logic [31:0] st;
    } sample_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [18:0] hd;
        logic [17:0] qz;
        logic [17:0] qw;
        logic [31:0] lin;
        logic [31:0] ang;
        logic        zi;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] right_angle = '0;
    logic signed [31:0] left_angle = '0;
    logic [31:0]        stamp_us = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] pos_x, pos_y, linear_velocity, angular_velocity;
    logic signed [18:0] heading;
    logic signed [17:0] quat_z, quat_w;
    logic               zero_interval;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = dd_odo_pkg::CFG_RADIUS;
    logic [19:0]        cfg_data = '0;

    diff_drive_wheel_odometry u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .right_angle(right_angle), .left_angle(left_angle), .stamp_us(stamp_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .quat_z(quat_z), .quat_w(quat_w),
        .linear_velocity(linear_velocity), .angular_velocity(angular_velocity),
        .zero_interval(zero_interval),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #(PERIOD_NS / 2) clk = ~clk;

    // pending samples and expected poses
    sample_t pending_samples[$];
    pose_t   expected_poses[$];

    // predictor copy of registers and state
    logic [31:0] p_radius = 32'd2163;
    logic [31:0] p_sep    = 32'd11141;
    logic [31:0] p_last_r = '0, p_last_l = '0, p_last_st = '0;
    logic [31:0] p_x = '0, p_y = '0;
    longint      p_head = 0;

    int  mismatches = 0;
    bit  quiet = 1'b0;       // no idling on either side
    int  hold_asked = 0;     // long receiver hold requests
    int  hold_served = 0;
    int  hold_left = 0;
    longint cycles = 0;

    // ------------------------------------------------------------------------
    // pose predictor
    // ------------------------------------------------------------------------
    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = GAIN_30;
        y = 0;
        z = ang;
        flip = 1'b0;
        // beyond a quarter turn, rotate by pi and negate afterwards
        if (z > HALF_PI_30) begin
            z = z - PI_30;
            flip = 1'b1;
        end else if (z < -HALF_PI_30) begin
            z = z + PI_30;
            flip = 1'b1;
        end
        for (int i = 0; i < dd_odo_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [17:0] quat_fx(input longint v);
        longint q;
        q = (v + 8192) >>> 14;
        if (q > 65536) q = 65536;
        if (q < -65536) q = -65536;
        return q[17:0];
    endfunction

    // rate = value * 1e6 / dt, rounded away from zero, saturated to int32
    function automatic logic [31:0] rate_of(input longint v, input logic [31:0] dt);
        longint unsigned mag, q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        if (mag >= (64'd1 << 44))
            q = 64'h1_0000_0000;
        else
            q = (mag * 64'd1000000 + dt / 2) / dt;
        if (v >= 0)
            return (q > 64'd2147483647) ? 32'h7FFF_FFFF : q[31:0];
        return (q > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(q));
    endfunction

    function automatic pose_t odo_advance(input sample_t sm);
        pose_t o;
        logic [31:0] d32, dt;
        longint dr, dl, r, sep, dmove, num, mag, q, turn, t, m, c, s, qc, qs;
        d32 = sm.ra - p_last_r;
        dr = longint'($signed(d32));
        d32 = sm.la - p_last_l;
        dl = longint'($signed(d32));
        dt = sm.st - p_last_st;
        r = longint'(p_radius);
        sep = (p_sep == 0) ? 1 : longint'(p_sep);
        p_last_r = sm.ra;
        p_last_l = sm.la;
        p_last_st = sm.st;

        dmove = (r * (dr + dl) + 65536) >>> 17;
        num = r * (dr - dl);
        mag = (num < 0) ? -num : num;
        q = (mag + sep / 2) / sep;
        turn = (num < 0) ? -q : q;

        // heading wraps to one turn about zero
        t = p_head + turn + PI_FX;
        m = t % TURN_FX;
        if (m < 0) m = m + TURN_FX;
        p_head = m - PI_FX;

        rotate(p_head * 16384, c, s);
        p_x = p_x + 32'((dmove * c + ROUND_30) >>> 30);
        p_y = p_y + 32'((dmove * s + ROUND_30) >>> 30);
        rotate(p_head * 8192, qc, qs);

        o.x = p_x;
        o.y = p_y;
        o.hd = p_head[18:0];
        o.qz = quat_fx(qs);
        o.qw = quat_fx(qc);
        o.zi = (dt == 0);
        o.lin = (dt == 0) ? 32'd0 : rate_of(dmove, dt);
        o.ang = (dt == 0) ? 32'd0 : rate_of(turn, dt);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // sample driver: pops the pending queue, predicts at each accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drv
        sample_t nx;
        sample_t taken;
        bit go;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                taken.ra = right_angle;
                taken.la = left_angle;
                taken.st = stamp_us;
                expected_poses.insert(expected_poses.size(), odo_advance(taken));
            end
            go = (pending_samples.size() > 0) && (quiet || $urandom_range(99) >= 11);
            if (go) begin
                nx = pending_samples.pop_front();
                right_angle <= nx.ra;
                left_angle <= nx.la;
                stamp_us <= nx.st;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold, counted in cycles
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : hold
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= 3000;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver stall
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : mon
        pose_t ex;
        bit bad;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: x=%h y=%h", pos_x, pos_y);
                end else begin
                    ex = expected_poses.pop_front();
                    bad = (pos_x !== ex.x) || (pos_y !== ex.y) || (heading !== ex.hd)
                        || (quat_z !== ex.qz) || (quat_w !== ex.qw)
                        || (linear_velocity !== ex.lin) || (angular_velocity !== ex.ang)
                        || (zero_interval !== ex.zi);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: x=%h y=%h hd=%h qz=%h qw=%h v=%h w=%h zi=%b",
                                ex.x, ex.y, ex.hd, ex.qz, ex.qw, ex.lin, ex.ang, ex.zi);
                            $display("         got: x=%h y=%h hd=%h qz=%h qw=%h v=%h w=%h zi=%b",
                                pos_x, pos_y, heading, quat_z, quat_w,
                                linear_velocity, angular_velocity, zero_interval);
                        end
                    end
                end
            end
            // long hold so the core fills and stalls its sample input
            if (hold_left > 0 || hold_asked != hold_served)
                out_stall <= 1'b1;
            else
                out_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    logic [31:0] g_r = '0, g_l = '0, g_st = '0;   // generator's last sample

    task automatic queue_sample(input logic [31:0] ra, input logic [31:0] la,
                                input logic [31:0] st);
        sample_t sm;
        sm.ra = ra;
        sm.la = la;
        sm.st = st;
        pending_samples.insert(pending_samples.size(), sm);
        g_r = ra;
        g_l = la;
        g_st = st;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_samples.size() > 0 || in_valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == dd_odo_pkg::CFG_RADIUS) p_radius = {16'd0, val[15:0]};
        else p_sep = {12'd0, val};
    endtask

    // mostly a wheel moving smoothly; some full-range noise and clock jumps
    task automatic queue_random(input int n);
        logic [31:0] dr, dl, dt;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 12) begin
                queue_sample($urandom, $urandom, $urandom);
            end else begin
                if (k < 80) begin
                    dr = $urandom_range(262144) - 131072;
                    dl = $urandom_range(262144) - 131072;
                end else if (k < 92) begin
                    dr = $urandom_range(16777216) - 8388608;
                    dl = -dr + $urandom_range(4096);
                end else begin
                    dr = $urandom;
                    dl = $urandom;
                end
                k = $urandom_range(99);
                if (k < 6) dt = 0;
                else if (k < 12) dt = $urandom_range(3) + 1;
                else if (k < 16) dt = $urandom;
                else dt = $urandom_range(20000) + 500;
                queue_sample(g_r + dr, g_l + dl, g_st + dt);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sample against zero, extremes, zero step, wraps
        queue_sample(32'd0, 32'd0, 32'd0);
        queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1000);
        queue_sample(32'h8000_0000, 32'h8000_0000, 32'd1000);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd1001);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd1002);
        queue_sample(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFF0);
        queue_sample(32'h0002_0000, 32'hFFFE_0000, 32'h0000_0010);
        queue_sample(32'h0002_0000, 32'hFFFE_0000, 32'h0000_0010);
        queue_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            queue_sample(g_r + 32'h0010_0000, g_l - 32'h0010_0000, g_st + 32'd5000);
        for (int i = 0; i < 4; i++)
            queue_sample(g_r - 32'h0003_0000, g_l - 32'h0003_0000, g_st + 32'd1);
        wait_drained();

        // radius and separation extremes
        write_reg(dd_odo_pkg::CFG_RADIUS, 20'hFFFF);
        write_reg(dd_odo_pkg::CFG_SEPARATION, 20'd1);
        queue_sample(g_r + 32'h7FFF_0000, g_l - 32'h7FFF_0000, g_st + 1);
        queue_sample(g_r + 32'h0000_0100, g_l, g_st + 32'hFFFF_FFFF);
        quiet = 1'b1;
        queue_random(150);
        wait_drained();
        quiet = 1'b0;

        // zero radius and zero separation
        write_reg(dd_odo_pkg::CFG_RADIUS, 20'd0);
        write_reg(dd_odo_pkg::CFG_SEPARATION, 20'd0);
        queue_random(60);
        wait_drained();
        write_reg(dd_odo_pkg::CFG_RADIUS, 20'd1);
        queue_random(60);
        wait_drained();

        // widest separation, back to nominal radius, long receiver hold
        write_reg(dd_odo_pkg::CFG_RADIUS, 20'd2163);
        write_reg(dd_odo_pkg::CFG_SEPARATION, 20'hFFFFF);
        hold_asked = hold_asked + 1;
        queue_random(200);
        wait_drained();

        // random settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(dd_odo_pkg::CFG_RADIUS, 20'($urandom_range(65535)));
            write_reg(dd_odo_pkg::CFG_SEPARATION, 20'($urandom_range(1048575)));
            queue_random(150);
            // sender pause until every result is in, then carry on
            wait_drained();
            queue_random(50);
            wait_drained();
        end

        // reset values again
        write_reg(dd_odo_pkg::CFG_RADIUS, 20'd2163);
        write_reg(dd_odo_pkg::CFG_SEPARATION, 20'd11141);
        queue_random(60);
        wait_drained();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
